/* hdl/rtph_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the rack tooth profile height block.
package rtph_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 24;
  localparam int X_W        = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int HEIGHT_W   = 28;
  localparam int R2_W       = 20;
  localparam int RAD_W      = R2_W + FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NCELLS     = ROOT_W;
  localparam int NORM_W     = 26;
  localparam int SLOPE_W    = 24;
  localparam int FPROD_W    = SLOPE_W + X_W + 1;
  localparam int DX_SQ_W    = 2 * X_W;
  localparam int MOD_W      = 24;
  localparam int HPROD_W    = NORM_W + MOD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULE_SCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLANK_BEGIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILLET_BEGIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILLET_CENTER_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILLET_CENTER_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLANK_SLOPE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLANK_OFFSET     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILLET_RADIUS_SQ = 3'd7;

  typedef enum logic [1:0] {
    REGION_HEAD   = 2'd0,
    REGION_FLANK  = 2'd1,
    REGION_FILLET = 2'd2,
    REGION_FLOOR  = 2'd3
  } region_t;

  typedef struct packed {
    logic        [MOD_W-1:0]   module_scale;
    logic        [15:0]        flank_begin;
    logic        [15:0]        fillet_begin;
    logic        [15:0]        fillet_center_x;
    logic signed [20:0]        fillet_center_y;
    logic signed [SLOPE_W-1:0] flank_slope;
    logic signed [23:0]        flank_offset;
    logic        [R2_W-1:0]    fillet_radius_sq;
  } cfg_t;

  typedef struct packed {
    region_t                  region;
    logic                     clamped;
    logic signed [NORM_W-1:0] flank_norm;
  } tag_t;

endpackage

/* hdl/rack_tooth_profile_height.sv */
`timescale 1ns / 1ps
// Rack tooth profile height: top level with front end, root chain and scaling.
//
// Usage: write the eight setup registers through cfg_wr_en, cfg_addr and
// cfg_wdata while no beat is in flight; each write is registered at the clock edge.
// An input beat is taken on every rising edge where start is high and busy
// is low. The block is fully pipelined, so busy stays low and a new
// position may enter in every cycle, one beat per clock sustained.
// Each result beat appears on height, region and root_clamped for exactly
// one cycle with done high, after three front stages (mirror and region,
// products, root argument), the 18-cell square root chain with one result
// bit per cell, one scaling multiply and one rounding and saturation
// stage. Results leave in input order.
// Reset clears all pipeline valid flags and loads the setup registers
// with their defaults (module of one, everything else zero); beats in
// flight at reset are dropped. The receiver cannot stall, so no result
// is ever held back.
module rack_tooth_profile_height (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rtph_pkg::POS_W-1:0]            position,
  output logic                                  done,
  output logic signed [rtph_pkg::HEIGHT_W-1:0]  height,
  output logic [1:0]                            region,
  output logic                                  root_clamped,
  input  logic                                  cfg_wr_en,
  input  logic [rtph_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [rtph_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import rtph_pkg::*;

  localparam logic [X_W-1:0] ONE  = X_W'(1) << FRAC_BITS;
  localparam logic [X_W-1:0] HALF = X_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [HPROD_W-1:0] H_MAX = HPROD_W'(134217727);
  localparam logic signed [HPROD_W-1:0] H_MIN = -HPROD_W'(134217728);

  cfg_t cfg;

  rtph_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  // Stage a: fraction, mirror and region.
  logic [X_W-1:0] frac;
  logic [X_W-1:0] x_in;
  region_t        region_in;
  logic           va;
  logic [X_W-1:0] xa;
  region_t        region_a;

  always_comb begin
    frac = {1'b0, position[FRAC_BITS-1:0]};
    x_in = (frac > HALF) ? (ONE - frac) : frac;
    if (x_in < X_W'(cfg.flank_begin)) begin
      region_in = REGION_HEAD;
    end else if (x_in < X_W'(cfg.fillet_begin)) begin
      region_in = REGION_FLANK;
    end else if (x_in < X_W'(cfg.fillet_center_x)) begin
      region_in = REGION_FILLET;
    end else begin
      region_in = REGION_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    xa       <= x_in;
    region_a <= region_in;
  end

  // Stage b: flank product and squared distance to the fillet center.
  logic                       vb;
  logic [X_W-1:0]             dx;
  logic signed [FPROD_W-1:0]  flank_prod;
  logic [DX_SQ_W-1:0]         dx_sq;
  region_t                    region_b;

  assign dx = (region_a == REGION_FILLET) ? (X_W'(cfg.fillet_center_x) - xa) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    flank_prod <= cfg.flank_slope * $signed({1'b0, xa});
    dx_sq      <= dx * dx;
    region_b   <= region_a;
  end

  // Stage c: root argument with clamp, rounded flank height.
  logic                         vc;
  logic signed [RAD_W:0]        arg;
  logic signed [FPROD_W-1:0]    flank_rnd;
  logic [RAD_W-1:0]             rad_c;
  tag_t                         tag_c;

  always_comb begin
    arg       = $signed({1'b0, cfg.fillet_radius_sq, FRAC_BITS'(0)})
              - $signed({(RAD_W + 1 - DX_SQ_W)'(0), dx_sq});
    flank_rnd = flank_prod + FPROD_W'(32'sd1 <<< (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    rad_c            <= arg[RAD_W] ? '0 : arg[RAD_W-1:0];
    tag_c.region     <= region_b;
    tag_c.clamped    <= arg[RAD_W];
    tag_c.flank_norm <= NORM_W'(flank_rnd >>> FRAC_BITS) + NORM_W'(cfg.flank_offset);
  end

  // Square root chain, one result bit per cell.
  logic              sq_valid [0:NCELLS];
  logic [RAD_W-1:0]  sq_rad   [0:NCELLS];
  logic [REM_W-1:0]  sq_rem   [0:NCELLS];
  logic [ROOT_W-1:0] sq_root  [0:NCELLS];
  tag_t              sq_tag   [0:NCELLS];

  assign sq_valid[0] = vc;
  assign sq_rad[0]   = rad_c;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_tag[0]   = tag_c;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rtph_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_tag    (sq_tag[i]),
      .out_valid (sq_valid[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_tag   (sq_tag[i+1])
    );
  end

  // Stage d: select normalized height and scale by the module.
  tag_t                      tag_end;
  logic signed [NORM_W-1:0]  norm;
  logic                      vd;
  logic signed [HPROD_W-1:0] hprod;
  region_t                   region_d;
  logic                      clamped_d;

  assign tag_end = sq_tag[NCELLS];

  always_comb begin
    case (tag_end.region)
      REGION_HEAD:  norm = $signed(NORM_W'(ONE));
      REGION_FLANK: norm = tag_end.flank_norm;
      default:      norm = NORM_W'(cfg.fillet_center_y)
                         - $signed(NORM_W'(sq_root[NCELLS]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= sq_valid[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    hprod     <= HPROD_W'(norm) * HPROD_W'($signed({1'b0, cfg.module_scale}));
    region_d  <= tag_end.region;
    clamped_d <= tag_end.clamped;
  end

  // Stage e: round, saturate and present the result beat.
  logic signed [HPROD_W-1:0] h_rnd;
  logic signed [HPROD_W-1:0] h_sh;

  always_comb begin
    h_rnd = hprod + HPROD_W'(32'sd1 <<< (FRAC_BITS - 1));
    h_sh  = h_rnd >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (h_sh > H_MAX) begin
      height <= H_MAX[HEIGHT_W-1:0];
    end else if (h_sh < H_MIN) begin
      height <= H_MIN[HEIGHT_W-1:0];
    end else begin
      height <= h_sh[HEIGHT_W-1:0];
    end
    region       <= region_d;
    root_clamped <= clamped_d;
  end

  a_clamp_only_fillet: assert property (@(posedge clk) disable iff (rst)
    done && root_clamped |-> region == REGION_FILLET)
    else $error("root clamp reported outside the fillet region");

  a_done_follows_chain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(sq_valid[NCELLS], 2))
    else $error("result beat without an item leaving the root chain");

  a_chain_latency: assert property (@(posedge clk) disable iff (rst)
    vd |-> $past(vc, NCELLS + 1))
    else $error("root chain latency mismatch");

endmodule

/* hdl/rtph_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the rack tooth profile height block.
module rtph_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rtph_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rtph_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output rtph_pkg::cfg_t                     cfg
);
  import rtph_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.module_scale     <= MOD_W'(1) << FRAC_BITS;
      cfg.flank_begin      <= '0;
      cfg.fillet_begin     <= '0;
      cfg.fillet_center_x  <= '0;
      cfg.fillet_center_y  <= '0;
      cfg.flank_slope      <= '0;
      cfg.flank_offset     <= '0;
      cfg.fillet_radius_sq <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MODULE_SCALE:     cfg.module_scale     <= cfg_wdata;
        REG_FLANK_BEGIN:      cfg.flank_begin      <= cfg_wdata[15:0];
        REG_FILLET_BEGIN:     cfg.fillet_begin     <= cfg_wdata[15:0];
        REG_FILLET_CENTER_X:  cfg.fillet_center_x  <= cfg_wdata[15:0];
        REG_FILLET_CENTER_Y:  cfg.fillet_center_y  <= $signed(cfg_wdata[20:0]);
        REG_FLANK_SLOPE:      cfg.flank_slope      <= $signed(cfg_wdata);
        REG_FLANK_OFFSET:     cfg.flank_offset     <= $signed(cfg_wdata);
        REG_FILLET_RADIUS_SQ: cfg.fillet_radius_sq <= cfg_wdata[R2_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/rtph_cell.sv */
`timescale 1ns / 1ps
// One digit cell of the pipelined square root chain.
module rtph_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rtph_pkg::RAD_W-1:0]    in_rad,
  input  logic [rtph_pkg::REM_W-1:0]    in_rem,
  input  logic [rtph_pkg::ROOT_W-1:0]   in_root,
  input  rtph_pkg::tag_t                in_tag,
  output logic                          out_valid,
  output logic [rtph_pkg::RAD_W-1:0]    out_rad,
  output logic [rtph_pkg::REM_W-1:0]    out_rem,
  output logic [rtph_pkg::ROOT_W-1:0]   out_root,
  output rtph_pkg::tag_t                out_tag
);
  import rtph_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;
  logic [REM_W+1:0] rem_new;

  always_comb begin
    rem_sh  = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial   = {2'b00, in_root, 2'b01};
    fits    = (rem_sh >= trial);
    rem_new = fits ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
    out_rem  <= rem_new[REM_W-1:0];
    out_root <= {in_root[ROOT_W-2:0], fits};
    out_tag  <= in_tag;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the rack tooth profile height block.
module tb_top;
  import rtph_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 30;

  class profile_scoreboard;
    typedef struct {
      logic signed [HEIGHT_W-1:0] height;
      region_t                    region;
      logic                       clamped;
    } profile_t;

    cfg_t     setup;
    profile_t expected_profiles[$];
    int       failures;

    function new();
      setup = '0;
      setup.module_scale = MOD_W'(1) << FRAC_BITS;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODULE_SCALE: setup.module_scale = data;
        REG_FLANK_BEGIN: setup.flank_begin = data[15:0];
        REG_FILLET_BEGIN: setup.fillet_begin = data[15:0];
        REG_FILLET_CENTER_X: setup.fillet_center_x = data[15:0];
        REG_FILLET_CENTER_Y: setup.fillet_center_y = data[20:0];
        REG_FLANK_SLOPE: setup.flank_slope = data;
        REG_FLANK_OFFSET: setup.flank_offset = data;
        REG_FILLET_RADIUS_SQ: setup.fillet_radius_sq = data[R2_W-1:0];
        default: ;
      endcase
    endfunction

    // Product of two Q.16 values, rounded half up back to Q.16.
    function longint round_product(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
    endfunction

    function longint floor_root(longint v);
      longint unsigned rem, root, probe;
      rem = v;
      root = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return longint'(root);
    endfunction

    function profile_t predict_profile(logic [POS_W-1:0] pos);
      profile_t e;
      longint one, x, norm, dx, arg, h;
      one = longint'(1) << FRAC_BITS;
      x = pos[FRAC_BITS-1:0];
      if (x > (one >> 1)) x = one - x;
      e.clamped = 1'b0;
      if (x < longint'(setup.flank_begin)) begin
        e.region = REGION_HEAD;
        norm = one;
      end else if (x < longint'(setup.fillet_begin)) begin
        e.region = REGION_FLANK;
        norm = round_product(setup.flank_slope, x) + longint'(setup.flank_offset);
      end else begin
        e.region = (x < longint'(setup.fillet_center_x)) ? REGION_FILLET : REGION_FLOOR;
        dx = (e.region == REGION_FILLET) ? longint'(setup.fillet_center_x) - x : 0;
        arg = (longint'(setup.fillet_radius_sq) << FRAC_BITS) - dx * dx;
        if (arg < 0) begin
          arg = 0;
          e.clamped = 1'b1;
        end
        norm = longint'(setup.fillet_center_y) - floor_root(arg);
      end
      h = round_product(norm, longint'(setup.module_scale));
      if (h > (longint'(1) << (HEIGHT_W - 1)) - 1) h = (longint'(1) << (HEIGHT_W - 1)) - 1;
      if (h < -(longint'(1) << (HEIGHT_W - 1))) h = -(longint'(1) << (HEIGHT_W - 1));
      e.height = h[HEIGHT_W-1:0];
      return e;
    endfunction

    function void note_position(logic [POS_W-1:0] pos);
      expected_profiles.insert(expected_profiles.size(), predict_profile(pos));
    endfunction

    function void check_profile(logic signed [HEIGHT_W-1:0] h, logic [1:0] r, logic c);
      profile_t e;
      if (expected_profiles.size() == 0) begin
        $error("unexpected result beat: height %0d, region %0d", h, r);
        failures++;
        return;
      end
      e = expected_profiles.pop_front();
      if (h !== e.height) begin
        $error("height: expected %0d, actual %0d", e.height, h);
        failures++;
      end
      if (r !== e.region) begin
        $error("region: expected %0d, actual %0d", e.region, r);
        failures++;
      end
      if (c !== e.clamped) begin
        $error("root_clamped: expected %0d, actual %0d", e.clamped, c);
        failures++;
      end
    endfunction

    function int pending();
      return expected_profiles.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [POS_W-1:0]           position = '0;
  logic                       done;
  logic signed [HEIGHT_W-1:0] height;
  logic [1:0]                 region;
  logic                       root_clamped;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_addr = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  int                         cycle_count = 0;

  profile_scoreboard sb = new();

  rack_tooth_profile_height u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .position     (position),
    .done         (done),
    .height       (height),
    .region       (region),
    .root_clamped (root_clamped),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rack_tooth_profile_height");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_profile(height, region, root_clamped);
  end

  task automatic send_beat(logic [POS_W-1:0] pos);
    start <= 1'b1;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_position(pos);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_setup(cfg_t s);
    logic [CFG_DATA_W-1:0] vals [8];
    int i;
    vals[REG_MODULE_SCALE] = s.module_scale;
    vals[REG_FLANK_BEGIN] = CFG_DATA_W'(s.flank_begin);
    vals[REG_FILLET_BEGIN] = CFG_DATA_W'(s.fillet_begin);
    vals[REG_FILLET_CENTER_X] = CFG_DATA_W'(s.fillet_center_x);
    vals[REG_FILLET_CENTER_Y] = CFG_DATA_W'(s.fillet_center_y);
    vals[REG_FLANK_SLOPE] = s.flank_slope;
    vals[REG_FLANK_OFFSET] = s.flank_offset;
    vals[REG_FILLET_RADIUS_SQ] = CFG_DATA_W'(s.fillet_radius_sq);
    wait_for_results();
    for (i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic cfg_t random_setup(int k);
    cfg_t s;
    logic [15:0] a, b, c, t;
    a = 16'($urandom_range(0, 32768));
    b = 16'($urandom_range(0, 32768));
    c = 16'($urandom_range(0, 32768));
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    if (k == 3) begin
      a = 16'd32768;
      b = 16'd32768;
      c = 16'd32768;
    end
    s.flank_begin = a;
    s.fillet_begin = b;
    s.fillet_center_x = c;
    s.fillet_center_y = 21'($urandom);
    s.flank_slope = 24'($urandom);
    s.flank_offset = 24'($urandom);
    if ($urandom_range(0, 1) != 0) s.fillet_radius_sq = R2_W'($urandom_range(0, 1048575));
    else s.fillet_radius_sq = R2_W'($urandom_range(0, 16384));
    case (k)
      0: s.module_scale = '0;
      1: s.module_scale = 24'hFFFFFF;
      default: begin
        if ($urandom_range(0, 3) == 0) s.module_scale = 24'($urandom);
        else s.module_scale = MOD_W'($urandom_range(16384, 4 * 65536));
      end
    endcase
    return s;
  endfunction

  // Mix of fully random positions and positions near the region edges.
  function automatic logic [POS_W-1:0] pick_position();
    logic [15:0] frac;
    int b;
    case ($urandom_range(0, 3))
      0: return POS_W'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0: b = sb.setup.flank_begin;
          1: b = sb.setup.fillet_begin;
          default: b = sb.setup.fillet_center_x;
        endcase
        b = b + int'($urandom_range(0, 6)) - 3;
        if (b < 0) b = 0;
        if (b > 32768) b = 32768;
        frac = b[15:0];
        if ($urandom_range(0, 1) != 0) frac = 16'(65536 - b);
      end
      default: frac = 16'($urandom_range(0, 65535));
    endcase
    return {8'($urandom), frac};
  endfunction

  task automatic send_stream(int count, bit with_gaps);
    int sent, burst, j;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (j = 0; j < burst && sent < count; j++) begin
        send_beat(pick_position());
        sent++;
      end
      if (with_gaps && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    cfg_t s;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults put every position on the floor at height zero.
    send_beat(24'h000000);
    send_beat(24'hFFFFFF);
    send_beat(24'h008000);
    send_beat(24'h008001);

    s = '{module_scale: 24'd131072, flank_begin: 16'd6554, fillet_begin: 16'd19661,
          fillet_center_x: 16'd22938, fillet_center_y: -21'sd49152,
          flank_slope: -24'sd655360, flank_offset: 24'sd131072, fillet_radius_sq: 20'd4096};
    load_setup(s);
    send_beat(24'h001999);
    send_beat(24'h00199A);
    send_beat(24'h004CCC);
    send_beat(24'h004CCD);
    send_beat(24'h00599A);
    send_beat(24'h00599B);
    send_beat({8'h2A, 16'd42598});
    send_beat(24'h017FFF);
    send_beat(24'h010000);
    send_beat(24'h00FFFF);

    // Radius of 1/256: the root argument goes negative one step past the circle edge.
    s = '{module_scale: 24'd65536, flank_begin: 16'd0, fillet_begin: 16'd0,
          fillet_center_x: 16'd32768, fillet_center_y: 21'sd0,
          flank_slope: 24'sd0, flank_offset: 24'sd0, fillet_radius_sq: 20'd1};
    load_setup(s);
    send_beat(24'h007F00);
    send_beat(24'h007EFF);
    send_beat(24'h000001);
    send_beat(24'h008000);

    s = '{module_scale: 24'hFFFFFF, flank_begin: 16'd0, fillet_begin: 16'd32768,
          fillet_center_x: 16'd32768, fillet_center_y: 21'sd1048575,
          flank_slope: 24'sd8388607, flank_offset: 24'sd8388607, fillet_radius_sq: 20'hFFFFF};
    load_setup(s);
    send_beat(24'h007FFF);
    send_beat(24'h008000);
    send_beat(24'h000000);

    s = '{module_scale: 24'hFFFFFF, flank_begin: 16'd0, fillet_begin: 16'd32768,
          fillet_center_x: 16'd0, fillet_center_y: -21'sd1048576,
          flank_slope: -24'sd8388608, flank_offset: -24'sd8388608, fillet_radius_sq: 20'hFFFFF};
    load_setup(s);
    send_beat(24'h007FFF);
    send_beat(24'h008000);

    for (k = 0; k < 9; k++) begin
      load_setup(random_setup(k));
      send_stream(100, (k % 2) == 0);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS rack_tooth_profile_height");
    end else begin
      $display("FAIL rack_tooth_profile_height");
    end
    $finish;
  end

endmodule
